/* design/grid_bilinear_interpolate_assert.svh */
// ----------------------------------------------------------------------------
// grid bilinear interpolate assertion macros
// clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef GRID_BILINEAR_INTERPOLATE_ASSERT_SVH
`define GRID_BILINEAR_INTERPOLATE_ASSERT_SVH
`ifndef SYNTHESIS
// condition implies consequence in the same cycle
`define GBI_ASSERT_SAME(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// condition implies consequence in the next cycle
`define GBI_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define GBI_ASSERT_SAME(lbl, pre, post)
`define GBI_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

/* design/gbi_pkg.sv */
// ----------------------------------------------------------------------------
// gbi_pkg
// shared types and codes for the grid bilinear interpolator
// ----------------------------------------------------------------------------
package gbi_pkg;

	// item opcodes
	localparam logic [1:0] OP_LOAD_X = 2'd0;
	localparam logic [1:0] OP_LOAD_Y = 2'd1;
	localparam logic [1:0] OP_LOAD_Z = 2'd2;
	localparam logic [1:0] OP_QUERY  = 2'd3;

	// result status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_SAT   = 2'd1;
	localparam logic [1:0] STATUS_DEGEN = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] REG_X_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Y_COUNT = 1'd1;
	localparam logic [CFG_DATA_W-1:0] COUNT_RESET = 7'd64;

	// arithmetic widths
	localparam int DIFF_W = 33;
	localparam int NUM_W  = 49;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [5:0]         row;
		logic [5:0]         col;
		logic signed [31:0] load_value;
		logic signed [31:0] query_x;
		logic signed [31:0] query_y;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] interp_z;
		logic [1:0]         status;
		logic [5:0]         cell_row;
		logic [5:0]         cell_col;
	} out_item_t;

	// divider result
	typedef struct packed {
		logic               done;
		logic               sat;
		logic signed [31:0] quo;
	} div_res_t;

endpackage

/* design/gbi_axis.sv */
// ----------------------------------------------------------------------------
// gbi_axis
// coordinate memory for one axis with first-match cell search
// ----------------------------------------------------------------------------
module gbi_axis #(
	parameter int MAX_POINTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [$clog2(MAX_POINTS)-1:0] waddr,
	input  logic signed [31:0]            wdata,
	input  logic                          start,
	input  logic [$clog2(MAX_POINTS)-1:0] last,
	input  logic signed [31:0]            query,
	output logic                          done,
	output logic [$clog2(MAX_POINTS)-1:0] lo_idx,
	output logic signed [31:0]            lo_coord,
	output logic signed [31:0]            hi_coord
);

	localparam int AW = $clog2(MAX_POINTS);

	localparam logic [2:0] AX_IDLE = 3'd0;
	localparam logic [2:0] AX_SCAN = 3'd1;
	localparam logic [2:0] AX_RDLO = 3'd2;
	localparam logic [2:0] AX_RDHI = 3'd3;
	localparam logic [2:0] AX_CAPT = 3'd4;
	localparam logic [2:0] AX_DONE = 3'd5;

	logic signed [31:0] coord_mem [MAX_POINTS];
	logic signed [31:0] rdata_q;
	logic [AW-1:0]      raddr;
	logic [2:0]         state_q;
	logic [AW-1:0]      addr_q;
	logic [AW-1:0]      chk_idx_q;
	logic               chk_v_q;
	logic [AW-1:0]      lo_q;
	logic signed [31:0] lo_coord_q;
	logic signed [31:0] hi_coord_q;
	logic               hit;

	// read address per phase
	always_comb begin
		case (state_q)
			AX_RDLO: raddr = lo_q;
			AX_RDHI: raddr = lo_q + AW'(1);
			default: raddr = addr_q;
		endcase
	end

	// coordinate memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (we) begin
			coord_mem[waddr] <= wdata;
		end
		rdata_q <= coord_mem[raddr];
	end

	// first entry not below the query, or the last one in use
	assign hit = chk_v_q && ((rdata_q >= query) || (chk_idx_q == last));

	// search sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= AX_IDLE;
			chk_v_q <= 1'b0;
		end else begin
			case (state_q)
				AX_IDLE, AX_DONE: begin
					if (start) begin
						chk_v_q <= 1'b0;
						state_q <= AX_SCAN;
					end
				end
				AX_SCAN: begin
					chk_v_q <= 1'b1;
					if (hit) begin
						state_q <= AX_RDLO;
					end
				end
				AX_RDLO: state_q <= AX_RDHI;
				AX_RDHI: state_q <= AX_CAPT;
				AX_CAPT: state_q <= AX_DONE;
				default: state_q <= AX_IDLE;
			endcase
		end
	end

	// scan address, cell index and coordinate capture
	always_ff @(posedge clk) begin
		if ((state_q == AX_IDLE || state_q == AX_DONE) && start) begin
			addr_q <= '0;
		end else if (state_q == AX_SCAN) begin
			addr_q    <= addr_q + AW'(1);
			chk_idx_q <= addr_q;
			if (hit) begin
				lo_q <= (chk_idx_q == '0) ? '0 : chk_idx_q - AW'(1);
			end
		end
		if (state_q == AX_RDHI) begin
			lo_coord_q <= rdata_q;
		end
		if (state_q == AX_CAPT) begin
			hi_coord_q <= rdata_q;
		end
	end

	assign done     = (state_q == AX_DONE);
	assign lo_idx   = lo_q;
	assign lo_coord = lo_coord_q;
	assign hi_coord = hi_coord_q;

endmodule

/* design/gbi_div.sv */
// ----------------------------------------------------------------------------
// gbi_div
// restoring signed divider, one quotient bit per cycle, saturated to 32 bits
// ----------------------------------------------------------------------------
module gbi_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [gbi_pkg::NUM_W-1:0]  num,
	input  logic signed [gbi_pkg::DIFF_W-1:0] den,
	output gbi_pkg::div_res_t                 res
);

	localparam int NW    = gbi_pkg::NUM_W;
	localparam int DW    = gbi_pkg::DIFF_W;
	localparam int CNT_W = $clog2(NW + 1);

	localparam logic [1:0] DV_IDLE = 2'd0;
	localparam logic [1:0] DV_RUN  = 2'd1;
	localparam logic [1:0] DV_FIX  = 2'd2;

	logic [1:0]         state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [NW-1:0]      quo_mag_q;
	logic [DW-1:0]      rem_q;
	logic [DW-1:0]      dmag_q;
	logic               neg_q;
	logic               done_q;
	logic               sat_q;
	logic signed [31:0] quo_q;
	logic [DW:0]        trial;
	logic               ge;
	logic [DW:0]        trial_sub;
	logic signed [NW:0] sq;
	logic               fits;

	// one restoring step
	assign trial     = {rem_q, quo_mag_q[NW-1]};
	assign ge        = trial >= {1'b0, dmag_q};
	assign trial_sub = trial - {1'b0, dmag_q};

	// apply sign and check range
	assign sq   = neg_q ? -$signed({1'b0, quo_mag_q}) : $signed({1'b0, quo_mag_q});
	assign fits = (&sq[NW:31]) || !(|sq[NW:31]);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			done_q  <= 1'b0;
		end else begin
			// done pulses for one cycle after the sign fix
			done_q <= (state_q == DV_FIX);
			case (state_q)
				DV_IDLE: begin
					if (start) begin
						state_q <= DV_RUN;
					end
				end
				DV_RUN: begin
					if (cnt_q == CNT_W'(NW - 1)) begin
						state_q <= DV_FIX;
					end
				end
				DV_FIX: state_q <= DV_IDLE;
				default: state_q <= DV_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == DV_IDLE && start) begin
			quo_mag_q <= num[NW-1] ? NW'(-num) : NW'(num);
			dmag_q    <= den[DW-1] ? DW'(-den) : DW'(den);
			neg_q     <= num[NW-1] ^ den[DW-1];
			rem_q     <= '0;
			cnt_q     <= '0;
		end else if (state_q == DV_RUN) begin
			rem_q     <= ge ? trial_sub[DW-1:0] : trial[DW-1:0];
			quo_mag_q <= {quo_mag_q[NW-2:0], ge};
			cnt_q     <= cnt_q + CNT_W'(1);
		end else if (state_q == DV_FIX) begin
			sat_q <= !fits;
			if (fits) begin
				quo_q <= sq[31:0];
			end else begin
				quo_q <= sq[NW] ? 32'sh8000_0000 : 32'sh7fff_ffff;
			end
		end
	end

	assign res.done = done_q;
	assign res.sat  = sat_q;
	assign res.quo  = quo_q;

endmodule

/* design/grid_bilinear_interpolate.sv */
// query time is set by the linear coordinate scan (one memory read per cycle)
// and two 49-step divisions sharing one divider; a degenerate cell skips the
// sample reads and divisions
// loads are written as they are accepted; one item is worked on at a time
// reset clears control state and sets both counts to 64; memories keep content
// ----------------------------------------------------------------------------
// grid_bilinear_interpolate
// rectilinear grid store with bilinear interpolation in signed q16.16
// ----------------------------------------------------------------------------
`include "grid_bilinear_interpolate_assert.svh"

module grid_bilinear_interpolate #(
	parameter int MAX_X_POINTS = 64,
	parameter int MAX_Y_POINTS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  gbi_pkg::in_item_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output gbi_pkg::out_item_t                  out_data,
	input  logic                                cfg_we,
	input  logic [gbi_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gbi_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int AWX    = $clog2(MAX_X_POINTS);
	localparam int AWY    = $clog2(MAX_Y_POINTS);
	localparam int ZDEPTH = MAX_X_POINTS * MAX_Y_POINTS;
	localparam int ZAW    = $clog2(ZDEPTH);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_AXIS  = 4'd1;
	localparam logic [3:0] ST_ZA    = 4'd2;
	localparam logic [3:0] ST_ZB    = 4'd3;
	localparam logic [3:0] ST_ZC    = 4'd4;
	localparam logic [3:0] ST_ZD    = 4'd5;
	localparam logic [3:0] ST_ZE    = 4'd6;
	localparam logic [3:0] ST_DIVX  = 4'd7;
	localparam logic [3:0] ST_DIVY  = 4'd8;
	localparam logic [3:0] ST_MUL   = 4'd9;
	localparam logic [3:0] ST_ADD   = 4'd10;
	localparam logic [3:0] ST_FIN   = 4'd11;

	logic [3:0]                   state_q;
	logic [gbi_pkg::CFG_DATA_W-1:0] x_count_q;
	logic [gbi_pkg::CFG_DATA_W-1:0] y_count_q;
	logic [AWX-1:0]               x_last;
	logic [AWY-1:0]               y_last;
	logic                         acc;
	logic                         acc_query;
	logic signed [31:0]           qx_q;
	logic signed [31:0]           qy_q;

	logic                         xwe;
	logic                         ywe;
	logic                         zwe;
	logic                         x_done;
	logic                         y_done;
	logic [AWX-1:0]               i1;
	logic [AWY-1:0]               j1;
	logic signed [31:0]           x1;
	logic signed [31:0]           x2;
	logic signed [31:0]           y1;
	logic signed [31:0]           y2;

	logic signed [31:0]           z_mem [ZDEPTH];
	logic signed [31:0]           zrd_q;
	logic [ZAW-1:0]               zwaddr;
	logic [ZAW-1:0]               zraddr;
	logic [AWX-1:0]               zi;
	logic [AWY-1:0]               zj;
	logic signed [31:0]           z11_q;
	logic signed [31:0]           z21_q;
	logic signed [31:0]           z12_q;
	logic signed [31:0]           z22_q;

	logic                         div_start;
	logic signed [gbi_pkg::NUM_W-1:0]  div_num;
	logic signed [gbi_pkg::DIFF_W-1:0] div_den;
	logic signed [gbi_pkg::DIFF_W-1:0] dq;
	gbi_pkg::div_res_t            div_res;
	logic signed [31:0]           tx_q;
	logic signed [31:0]           ty_q;

	logic [1:0]                   step_q;
	logic signed [31:0]           la;
	logic signed [31:0]           lb;
	logic signed [31:0]           lt;
	logic signed [32:0]           ldiff;
	logic signed [64:0]           prod_q;
	logic signed [49:0]           lsum;
	logic                         lfits;
	logic signed [31:0]           lres;
	logic signed [31:0]           z1_q;
	logic signed [31:0]           z2_q;
	logic signed [31:0]           res_z_q;
	logic                         sat_q;
	logic                         degen_q;
	logic                         out_valid_q;
	gbi_pkg::out_item_t           out_data_q;
	logic                         out_free;

	// input handshake: one item in flight
	assign in_stall  = (state_q != ST_IDLE);
	assign acc       = in_valid && !in_stall;
	assign acc_query = acc && (in_data.opcode == gbi_pkg::OP_QUERY);
	assign out_free  = !out_valid_q || !out_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_count_q <= gbi_pkg::COUNT_RESET;
			y_count_q <= gbi_pkg::COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				gbi_pkg::REG_X_COUNT: x_count_q <= cfg_data;
				gbi_pkg::REG_Y_COUNT: y_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// last index in use per axis, count clamped to 2..max
	always_comb begin
		if (x_count_q < 7'd2) begin
			x_last = AWX'(1);
		end else if (32'(x_count_q) > MAX_X_POINTS) begin
			x_last = AWX'(MAX_X_POINTS - 1);
		end else begin
			x_last = AWX'(x_count_q - 7'd1);
		end
		if (y_count_q < 7'd2) begin
			y_last = AWY'(1);
		end else if (32'(y_count_q) > MAX_Y_POINTS) begin
			y_last = AWY'(MAX_Y_POINTS - 1);
		end else begin
			y_last = AWY'(y_count_q - 7'd1);
		end
	end

	// load decode, indexes beyond the stores are dropped
	assign xwe = acc && (in_data.opcode == gbi_pkg::OP_LOAD_X)
		&& (32'(in_data.row) < MAX_X_POINTS);
	assign ywe = acc && (in_data.opcode == gbi_pkg::OP_LOAD_Y)
		&& (32'(in_data.col) < MAX_Y_POINTS);
	assign zwe = acc && (in_data.opcode == gbi_pkg::OP_LOAD_Z)
		&& (32'(in_data.row) < MAX_X_POINTS) && (32'(in_data.col) < MAX_Y_POINTS);

	gbi_axis #(
		.MAX_POINTS (MAX_X_POINTS)
	) u_x_axis (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (xwe),
		.waddr    (AWX'(in_data.row)),
		.wdata    (in_data.load_value),
		.start    (acc_query),
		.last     (x_last),
		.query    (qx_q),
		.done     (x_done),
		.lo_idx   (i1),
		.lo_coord (x1),
		.hi_coord (x2)
	);

	gbi_axis #(
		.MAX_POINTS (MAX_Y_POINTS)
	) u_y_axis (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (ywe),
		.waddr    (AWY'(in_data.col)),
		.wdata    (in_data.load_value),
		.start    (acc_query),
		.last     (y_last),
		.query    (qy_q),
		.done     (y_done),
		.lo_idx   (j1),
		.lo_coord (y1),
		.hi_coord (y2)
	);

	// sample addresses, row major
	always_comb begin
		case (state_q)
			ST_ZB:   begin zi = i1 + AWX'(1); zj = j1;            end
			ST_ZC:   begin zi = i1;           zj = j1 + AWY'(1);  end
			ST_ZD:   begin zi = i1 + AWX'(1); zj = j1 + AWY'(1);  end
			default: begin zi = i1;           zj = j1;            end
		endcase
	end
	assign zraddr = ZAW'(ZAW'(zi) * ZAW'(MAX_Y_POINTS) + ZAW'(zj));
	assign zwaddr = ZAW'(ZAW'(in_data.row) * ZAW'(MAX_Y_POINTS) + ZAW'(in_data.col));

	// sample memory
	always_ff @(posedge clk) begin
		if (zwe) begin
			z_mem[zwaddr] <= in_data.load_value;
		end
		zrd_q <= z_mem[zraddr];
	end

	// divider operands: x fraction first, then y
	always_comb begin
		if (state_q == ST_DIVX) begin
			dq      = 33'(qy_q) - 33'(y1);
			div_den = 33'(y2) - 33'(y1);
		end else begin
			dq      = 33'(qx_q) - 33'(x1);
			div_den = 33'(x2) - 33'(x1);
		end
		div_num = {dq, 16'd0};
	end
	assign div_start = (state_q == ST_ZE) || (state_q == ST_DIVX && div_res.done);

	gbi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.res    (div_res)
	);

	// lerp operand select
	always_comb begin
		case (step_q)
			2'd0:    begin la = z11_q; lb = z21_q; lt = tx_q; end
			2'd1:    begin la = z12_q; lb = z22_q; lt = tx_q; end
			default: begin la = z1_q;  lb = z2_q;  lt = ty_q; end
		endcase
	end
	assign ldiff = 33'(lb) - 33'(la);

	// a + floor(prod / 65536), saturated
	assign lsum  = 50'(la) + 50'($signed(prod_q[64:16]));
	assign lfits = (&lsum[49:31]) || !(|lsum[49:31]);
	assign lres  = lfits ? lsum[31:0] : (lsum[49] ? 32'sh8000_0000 : 32'sh7fff_ffff);

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc_query) begin
						state_q <= ST_AXIS;
					end
				end
				ST_AXIS: begin
					if (x_done && y_done) begin
						state_q <= (x1 == x2 || y1 == y2) ? ST_FIN : ST_ZA;
					end
				end
				ST_ZA: state_q <= ST_ZB;
				ST_ZB: state_q <= ST_ZC;
				ST_ZC: state_q <= ST_ZD;
				ST_ZD: state_q <= ST_ZE;
				ST_ZE: state_q <= ST_DIVX;
				ST_DIVX: begin
					if (div_res.done) begin
						state_q <= ST_DIVY;
					end
				end
				ST_DIVY: begin
					if (div_res.done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_ADD;
				ST_ADD: state_q <= (step_q == 2'd2) ? ST_FIN : ST_MUL;
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// result valid: set when the result is loaded, cleared once taken
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (acc_query) begin
			qx_q    <= in_data.query_x;
			qy_q    <= in_data.query_y;
			sat_q   <= 1'b0;
			degen_q <= 1'b0;
			step_q  <= 2'd0;
		end
		if (state_q == ST_AXIS && x_done && y_done && (x1 == x2 || y1 == y2)) begin
			degen_q <= 1'b1;
			res_z_q <= '0;
		end
		// sample captures trail the address through the registered memory read
		if (state_q == ST_ZB) z11_q <= zrd_q;
		if (state_q == ST_ZC) z21_q <= zrd_q;
		if (state_q == ST_ZD) z12_q <= zrd_q;
		if (state_q == ST_ZE) z22_q <= zrd_q;
		if (state_q == ST_DIVX && div_res.done) begin
			tx_q  <= div_res.quo;
			sat_q <= sat_q | div_res.sat;
		end
		if (state_q == ST_DIVY && div_res.done) begin
			ty_q  <= div_res.quo;
			sat_q <= sat_q | div_res.sat;
		end
		if (state_q == ST_MUL) begin
			prod_q <= ldiff * lt;
		end
		if (state_q == ST_ADD) begin
			sat_q  <= sat_q | !lfits;
			step_q <= step_q + 2'd1;
			case (step_q)
				2'd0:    z1_q    <= lres;
				2'd1:    z2_q    <= lres;
				default: res_z_q <= lres;
			endcase
		end
		// result register
		if (state_q == ST_FIN && out_free) begin
			out_data_q.interp_z <= res_z_q;
			out_data_q.cell_row <= 6'(i1);
			out_data_q.cell_col <= 6'(j1);
			if (degen_q) begin
				out_data_q.status <= gbi_pkg::STATUS_DEGEN;
			end else if (sat_q) begin
				out_data_q.status <= gbi_pkg::STATUS_SAT;
			end else begin
				out_data_q.status <= gbi_pkg::STATUS_OK;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// a degenerate cell always reports zero
	`GBI_ASSERT_SAME(a_degen_zero, out_valid && out_data.status == gbi_pkg::STATUS_DEGEN, out_data.interp_z == 32'sd0)
	// an accepted query leaves idle
	`GBI_ASSERT_NEXT(a_query_busy, acc_query, state_q != ST_IDLE)
	// divider only finishes while the sequencer waits on it
	`GBI_ASSERT_SAME(a_div_owner, div_res.done, state_q == ST_DIVX || state_q == ST_DIVY)
	// status is one of the defined codes
	`GBI_ASSERT_SAME(a_status_code, out_valid, out_data.status == gbi_pkg::STATUS_OK || out_data.status == gbi_pkg::STATUS_SAT || out_data.status == gbi_pkg::STATUS_DEGEN)

endmodule

/* tb/tb_grid_bilinear_interpolate.sv */
// ----------------------------------------------------------------------------
// tb_grid_bilinear_interpolate
// self-checking bench for the rectilinear grid bilinear interpolator: fills
// the grid, walks a directed table, then runs random load and query traffic
// across several count settings and idle patterns, checking every result
// against a built-in q16.16 predictor
// ----------------------------------------------------------------------------
module tb_grid_bilinear_interpolate;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPTS        = 64;
	// rows and columns that hold samples; the last coordinate of each axis
	// sits at the top of the range so every search stops inside this block
	localparam int GRID        = 16;
	localparam logic [31:0] COORD_TOP = 32'h7FFF_FFFF;
	localparam int PHASE_ITEMS = 58;
	localparam int STALL_LIM   = 5000;
	localparam int DRAIN_WAIT  = 250;

	typedef struct {
		gbi_pkg::in_item_t  item;
		bit                 typed;
		gbi_pkg::out_item_t want;
	} dir_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	gbi_pkg::in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	gbi_pkg::out_item_t out_data;
	logic      cfg_we = 1'b0;
	logic [gbi_pkg::CFG_IDX_W-1:0]  cfg_index = gbi_pkg::REG_X_COUNT;
	logic [gbi_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// grid predictor state
	logic signed [31:0] x_grid [NPTS];
	logic signed [31:0] y_grid [NPTS];
	logic signed [31:0] z_grid [NPTS*NPTS];
	logic [6:0] x_cnt_reg = 7'd64;
	logic [6:0] y_cnt_reg = 7'd64;

	gbi_pkg::out_item_t expected_results [$];
	dir_row_t  dir_tbl [$];
	int  mismatches = 0;
	int  send_idle_pct = 0;
	int  stall_pct = 0;
	int  quiet_cycles = 0;

	logic [6:0] phase_x [6] = '{7'd0, 7'd127, 7'd2, 7'd65, 7'd1, 7'd64};
	logic [6:0] phase_y [6] = '{7'd127, 7'd1, 7'd2, 7'd40, 7'd64, 7'd64};
	int idle_in [4] = '{0, 63, 0, 9};
	int idle_out [4] = '{0, 0, 63, 9};

	always #10 clk = ~clk;

	grid_bilinear_interpolate u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clamp to signed 32 bits, flagging saturation
	function automatic longint clip32(input longint v, inout bit sat);
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			sat = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic int eff_count(input logic [6:0] c);
		if (c < 2) return 2;
		if (c > NPTS) return NPTS;
		return int'(c);
	endfunction

	// first coordinate not below q, clamped to 1..n-1
	function automatic int upper_index(input bit use_y, input int n, input longint q);
		int idx;
		longint c;
		idx = n;
		for (int i = 0; i < n; i++) begin
			c = use_y ? longint'(y_grid[i]) : longint'(x_grid[i]);
			if (c >= q) begin
				idx = i;
				break;
			end
		end
		if (idx >= n) idx = n - 1;
		if (idx == 0) idx = 1;
		return idx;
	endfunction

	function automatic longint lerp(input longint a, input longint b, input longint t,
			inout bit sat);
		return clip32(a + ((b - a) * t >>> 16), sat);
	endfunction

	// apply one item to the grid copy; returns 1 when a result is due
	function automatic bit predict_grid_item(input gbi_pkg::in_item_t it,
			output gbi_pkg::out_item_t r);
		int i1, i2, j1, j2;
		longint qx, qy, x1, x2, y1, y2, tx, ty, z1, z2, zv;
		bit sat;
		r = '0;
		sat = 1'b0;
		case (it.opcode)
			gbi_pkg::OP_LOAD_X: begin
				x_grid[it.row] = it.load_value;
				return 1'b0;
			end
			gbi_pkg::OP_LOAD_Y: begin
				y_grid[it.col] = it.load_value;
				return 1'b0;
			end
			gbi_pkg::OP_LOAD_Z: begin
				z_grid[it.row*NPTS + it.col] = it.load_value;
				return 1'b0;
			end
			default: ;
		endcase
		qx = longint'(it.query_x);
		qy = longint'(it.query_y);
		i2 = upper_index(1'b0, eff_count(x_cnt_reg), qx);
		j2 = upper_index(1'b1, eff_count(y_cnt_reg), qy);
		i1 = i2 - 1;
		j1 = j2 - 1;
		x1 = longint'(x_grid[i1]);
		x2 = longint'(x_grid[i2]);
		y1 = longint'(y_grid[j1]);
		y2 = longint'(y_grid[j2]);
		r.cell_row = i1[5:0];
		r.cell_col = j1[5:0];
		if (x1 == x2 || y1 == y2) begin
			r.interp_z = '0;
			r.status = gbi_pkg::STATUS_DEGEN;
			return 1'b1;
		end
		tx = clip32(((qx - x1) * 65536) / (x2 - x1), sat);
		ty = clip32(((qy - y1) * 65536) / (y2 - y1), sat);
		z1 = lerp(longint'(z_grid[i1*NPTS + j1]), longint'(z_grid[i2*NPTS + j1]), tx, sat);
		z2 = lerp(longint'(z_grid[i1*NPTS + j2]), longint'(z_grid[i2*NPTS + j2]), tx, sat);
		zv = lerp(z1, z2, ty, sat);
		r.interp_z = zv[31:0];
		r.status = sat ? gbi_pkg::STATUS_SAT : gbi_pkg::STATUS_OK;
		return 1'b1;
	endfunction

	// one input transfer, with an optional sender gap afterwards
	task automatic send_item(input gbi_pkg::in_item_t it, input bit typed,
			input gbi_pkg::out_item_t want);
		gbi_pkg::out_item_t r;
		bit has;
		in_data <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		has = predict_grid_item(it, r);
		if (has) expected_results.insert(expected_results.size(), typed ? want : r);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
		end
	endtask

	// append one row to the directed table
	task automatic add_row(input gbi_pkg::in_item_t it, input bit typed,
			input gbi_pkg::out_item_t want);
		dir_row_t dr;
		dr.item = it;
		dr.typed = typed;
		dr.want = want;
		dir_tbl.insert(dir_tbl.size(), dr);
	endtask

	function automatic gbi_pkg::in_item_t load_item(input logic [1:0] op, input int r,
			input int c, input logic [31:0] v);
		gbi_pkg::in_item_t it;
		it = '0;
		it.opcode = op;
		it.row = r[5:0];
		it.col = c[5:0];
		it.load_value = v;
		return it;
	endfunction

	function automatic gbi_pkg::in_item_t query_item(input logic [31:0] qx,
			input logic [31:0] qy);
		gbi_pkg::in_item_t it;
		it = '0;
		it.opcode = gbi_pkg::OP_QUERY;
		it.query_x = qx;
		it.query_y = qy;
		return it;
	endfunction

	task automatic send_plain(input gbi_pkg::in_item_t it);
		send_item(it, 1'b0, '0);
	endtask

	function automatic logic [31:0] rand_sample();
		if ($urandom_range(0, 9) == 0) return $urandom();
		return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
	endfunction

	// sorted coordinate lists below the top entry, with repeated values when degen is set
	task automatic load_coords(input bit degen);
		longint v;
		for (int ax = 0; ax < 2; ax++) begin
			v = longint'($urandom_range(0, 32'h2000_0000)) - 64'sh1000_0000;
			for (int k = 0; k < GRID - 1; k++) begin
				send_plain(load_item(ax ? gbi_pkg::OP_LOAD_Y : gbi_pkg::OP_LOAD_X,
					k, k, v[31:0]));
				if (!(degen && $urandom_range(0, 7) == 0))
					v += $urandom_range(1, 32'h0004_0000);
			end
		end
	endtask

	// query coordinate near the grid span, on a node, or anywhere
	function automatic logic [31:0] rand_query(input bit use_y);
		longint lo, hi;
		int n, pick;
		n = eff_count(use_y ? y_cnt_reg : x_cnt_reg);
		if (n > GRID - 1) n = GRID - 1;
		pick = $urandom_range(0, 99);
		lo = use_y ? longint'(y_grid[0]) : longint'(x_grid[0]);
		hi = use_y ? longint'(y_grid[n-1]) : longint'(x_grid[n-1]);
		if (pick < 15) begin
			pick = $urandom_range(0, n - 1);
			return use_y ? y_grid[pick] : x_grid[pick];
		end
		lo -= 64'sh0010_0000;
		hi += 64'sh0010_0000;
		if (pick < 85 && hi > lo && hi - lo < 64'sh8000_0000) begin
			lo += $urandom_range(0, 32'(hi - lo));
			return lo[31:0];
		end
		return $urandom();
	endfunction

	// register writes only with the block drained
	task automatic write_counts(input logic [6:0] xc, input logic [6:0] yc);
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= gbi_pkg::REG_X_COUNT;
		cfg_data <= xc;
		@(posedge clk);
		cfg_index <= gbi_pkg::REG_Y_COUNT;
		cfg_data <= yc;
		@(posedge clk);
		cfg_we <= 1'b0;
		x_cnt_reg = xc;
		y_cnt_reg = yc;
		@(posedge clk);
	endtask

	// result checker and receiver stall
	always @(posedge clk) begin
		gbi_pkg::out_item_t want;
		if (arst_n) begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result z=%h st=%0d cell=%0d,%0d",
							out_data.interp_z, out_data.status,
							out_data.cell_row, out_data.cell_col);
				end else begin
					want = expected_results.pop_front();
					if (out_data.interp_z !== want.interp_z || out_data.status !== want.status
							|| out_data.cell_row !== want.cell_row
							|| out_data.cell_col !== want.cell_col) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp z=%h st=%0d cell=%0d,%0d got z=%h st=%0d cell=%0d,%0d",
								want.interp_z, want.status, want.cell_row, want.cell_col,
								out_data.interp_z, out_data.status,
								out_data.cell_row, out_data.cell_col);
					end
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIM) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		gbi_pkg::out_item_t typed_res;
		gbi_pkg::out_item_t no_res;
		logic [31:0] qx, qy, cv;
		int pick;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the used block: unit-spaced coordinates, top entry at the range end
		for (int k = 0; k < GRID; k++) begin
			cv = (k < GRID - 1) ? 32'(k << 16) : COORD_TOP;
			send_plain(load_item(gbi_pkg::OP_LOAD_X, k, 0, cv));
			send_plain(load_item(gbi_pkg::OP_LOAD_Y, 0, k, cv));
		end
		for (int r = 0; r < GRID; r++)
			for (int c = 0; c < GRID; c++)
				send_plain(load_item(gbi_pkg::OP_LOAD_Z, r, c, rand_sample()));

		// directed table
		no_res = '0;
		typed_res = '0;
		add_row(load_item(gbi_pkg::OP_LOAD_Z, 0, 0, 32'h1234_0000), 1'b0, no_res);
		typed_res.interp_z = 32'h1234_0000;
		typed_res.status = gbi_pkg::STATUS_OK;
		add_row(query_item(32'h0, 32'h0), 1'b1, typed_res);
		add_row(query_item(32'h8000_0000, 32'h8000_0000), 1'b0, no_res);
		add_row(query_item(32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b0, no_res);
		add_row(query_item(32'h0005_0000, 32'h0003_8000), 1'b0, no_res);
		// extreme samples force saturation
		add_row(load_item(gbi_pkg::OP_LOAD_Z, 0, 0, 32'h7FFF_FFFF), 1'b0, no_res);
		add_row(load_item(gbi_pkg::OP_LOAD_Z, 1, 1, 32'h8000_0000), 1'b0, no_res);
		add_row(query_item(32'h0000_8000, 32'h0000_8000), 1'b0, no_res);
		add_row(query_item(32'hFFF0_0000, 32'h0000_4000), 1'b0, no_res);
		// top corner sample of the used block
		add_row(load_item(gbi_pkg::OP_LOAD_Z, GRID - 1, GRID - 1, 32'h8000_0000), 1'b0,
			no_res);
		add_row(query_item(32'h000F_0000, 32'h000F_8000), 1'b0, no_res);
		// equal x coordinates give a degenerate cell
		add_row(load_item(gbi_pkg::OP_LOAD_X, 1, 0, 32'h0), 1'b0, no_res);
		typed_res.interp_z = '0;
		typed_res.status = gbi_pkg::STATUS_DEGEN;
		add_row(query_item(32'h0, 32'h0), 1'b1, typed_res);
		add_row(load_item(gbi_pkg::OP_LOAD_X, 1, 0, 32'h0001_0000), 1'b0, no_res);
		// out-of-order y coordinate
		add_row(load_item(gbi_pkg::OP_LOAD_Y, 0, 3, 32'h7FFF_FFFF), 1'b0, no_res);
		add_row(query_item(32'h0002_0000, 32'h0010_0000), 1'b0, no_res);
		add_row(query_item(32'h0002_0000, 32'h7FFF_FFFF), 1'b0, no_res);
		add_row(load_item(gbi_pkg::OP_LOAD_Y, 0, 3, 32'h0003_0000), 1'b0, no_res);
		add_row(query_item(32'h0020_0000, 32'h0020_0000), 1'b0, no_res);
		foreach (dir_tbl[i])
			send_item(dir_tbl[i].item, dir_tbl[i].typed, dir_tbl[i].want);

		// random phases over count settings and idle patterns
		for (int ph = 0; ph < 8; ph++) begin
			if (ph < 6) write_counts(phase_x[ph], phase_y[ph]);
			else write_counts($urandom_range(0, 127), $urandom_range(0, 127));
			send_idle_pct = idle_in[ph % 4];
			stall_pct = idle_out[ph % 4];
			if (ph >= 2) load_coords(ph == 4 || ph == 7);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 6)
					send_plain(load_item(gbi_pkg::OP_LOAD_Z, $urandom_range(0, 63),
						$urandom_range(0, 63), rand_sample()));
				else if (pick < 9)
					send_plain(load_item($urandom_range(0, 1) ? gbi_pkg::OP_LOAD_X
						: gbi_pkg::OP_LOAD_Y, $urandom_range(0, GRID - 2),
						$urandom_range(0, GRID - 2), $urandom()));
				else begin
					qx = rand_query(1'b0);
					qy = rand_query(1'b1);
					send_plain(query_item(qx, qy));
				end
			end
		end

		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* files.f */
+incdir+design
design/gbi_pkg.sv
design/gbi_axis.sv
design/gbi_div.sv
design/grid_bilinear_interpolate.sv
tb/tb_grid_bilinear_interpolate.sv
